[rtl/core/ssfr_pkg.sv]
package ssfr_pkg;

	// Frame limits and timing
	localparam int unsigned MAX_PAYLOAD_DEF = 8;
	localparam int unsigned TICKS_W = 20;
	localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 20'd25000;
	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	// APB register map
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_TIMEOUT = 1'b0;

	// Input word actions
	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	// Result codes
	typedef enum logic [1:0] {
		RC_OK       = 2'd0,
		RC_TIMEOUT  = 2'd1,
		RC_HEADER   = 2'd2,
		RC_CHECKSUM = 2'd3
	} result_code_t;

	// One input word
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] byte_value;
		logic [7:0] target_id;
		logic [3:0] expected_length;
	} item_t;

	// One result word
	typedef struct packed {
		logic [1:0]  result_code;
		logic [63:0] payload_bytes;
	} result_t;

endpackage

[rtl/core/ssfr_in_if.sv]
interface ssfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] byte_value;
	logic [7:0] target_id;
	logic [3:0] expected_length;

	modport source (
		output valid, action, byte_value, target_id, expected_length,
		input  ready
	);
	modport sink (
		input  valid, action, byte_value, target_id, expected_length,
		output ready
	);
endinterface

[rtl/core/ssfr_out_if.sv]
interface ssfr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [63:0] payload_bytes;

	modport source (
		output valid, result_code, payload_bytes,
		input  ready
	);
	modport sink (
		input  valid, result_code, payload_bytes,
		output ready
	);
endinterface

[rtl/core/servo_status_frame_receiver_top.sv]
// Servo status frame receiver.
// A word is registered in the input stage and its result in the result register.
// Throughput: one input word per cycle; the frame state update sets the rate.
// The input stage stalls only while the result register holds a word not yet taken.
// arst_n clears the frame state to idle and timeout_ticks to 25000 asynchronously.
module servo_status_frame_receiver_top #(
	parameter int unsigned MAX_PAYLOAD = ssfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ssfr_in_if.sink                       frame,
	ssfr_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssfr_pkg::PADDR_W-1:0]  paddr,
	input  logic [ssfr_pkg::PDATA_W-1:0]  pwdata,
	output logic [ssfr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic [ssfr_pkg::TICKS_W-1:0] timeout_q;
	logic                         valid_s1;
	ssfr_pkg::item_t              item_s1;
	logic                         res_valid_q;
	ssfr_pkg::result_t            res_q;
	logic                         adv;
	logic                         p_valid;
	ssfr_pkg::result_t            p_res;

	// Config register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ssfr_pkg::REG_TIMEOUT)
		? ssfr_pkg::PDATA_W'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ssfr_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ssfr_pkg::REG_TIMEOUT) begin
			timeout_q <= pwdata[ssfr_pkg::TICKS_W-1:0];
		end
	end

	// Handshake: input stage moves whenever the result slot is free
	assign adv         = !res_valid_q || result.ready;
	assign frame.ready = !valid_s1 || adv;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			item_s1.action          <= frame.action;
			item_s1.byte_value      <= frame.byte_value;
			item_s1.target_id       <= frame.target_id;
			item_s1.expected_length <= frame.expected_length;
		end
	end

	ssfr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1 && adv),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.res_valid     (p_valid),
		.res           (p_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1 && p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && p_valid) begin
			res_q <= p_res;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.result_code   = res_q.result_code;
	assign result.payload_bytes = res_q.payload_bytes;

endmodule

[rtl/core/ssfr_parser.sv]
module ssfr_parser #(
	parameter int unsigned MAX_PAYLOAD = ssfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  ssfr_pkg::item_t              item,
	input  logic [ssfr_pkg::TICKS_W-1:0] timeout_ticks,
	output logic                         res_valid,
	output ssfr_pkg::result_t            res
);

	localparam int unsigned PW = 8 * MAX_PAYLOAD;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_HUNT   = 7'b0000010,
		PH_ID     = 7'b0000100,
		PH_LEN    = 7'b0001000,
		PH_STATUS = 7'b0010000,
		PH_DATA   = 7'b0100000,
		PH_CHECK  = 7'b1000000
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic                         last_ff_q, last_ff_d;
	logic [7:0]                   armed_id_q, armed_id_d;
	logic [3:0]                   armed_len_q, armed_len_d;
	logic                         hdr_bad_q, hdr_bad_d;
	logic [3:0]                   count_q, count_d;
	logic [7:0]                   sum_q, sum_d;
	logic [PW-1:0]                store_q, store_d;
	logic [ssfr_pkg::TICKS_W-1:0] ticks_q, ticks_d;

	logic [7:0] b;
	logic [7:0] sum_add;
	logic [3:0] count_inc;
	logic       hdr_bad_now;

	assign b         = item.byte_value;
	assign sum_add   = sum_q + b;
	assign count_inc = count_q + 4'd1;
	assign hdr_bad_now = hdr_bad_q || (b != 8'd0) || (armed_len_q > 4'(MAX_PAYLOAD));

	// Next-state and result for the word in the input stage
	always_comb begin
		phase_d     = phase_q;
		last_ff_d   = last_ff_q;
		armed_id_d  = armed_id_q;
		armed_len_d = armed_len_q;
		hdr_bad_d   = hdr_bad_q;
		count_d     = count_q;
		sum_d       = sum_q;
		store_d     = store_q;
		ticks_d     = ticks_q;
		res_valid   = 1'b0;
		res.result_code   = ssfr_pkg::RC_OK;
		res.payload_bytes = 64'd0;

		if (step) begin
			if (item.action == ssfr_pkg::ACT_START) begin
				armed_id_d  = item.target_id;
				armed_len_d = item.expected_length;
				ticks_d     = timeout_ticks;
				last_ff_d   = 1'b0;
				hdr_bad_d   = 1'b0;
				count_d     = 4'd0;
				sum_d       = 8'd0;
				store_d     = '0;
				phase_d     = PH_HUNT;
			end else if (phase_q != PH_IDLE) begin
				if (item.action == ssfr_pkg::ACT_BYTE) begin
					unique case (phase_q)
						PH_HUNT: begin
							if (last_ff_q && b == ssfr_pkg::SYNC_BYTE)
								phase_d = PH_ID;
							last_ff_d = (b == ssfr_pkg::SYNC_BYTE);
						end
						PH_ID: begin
							hdr_bad_d = (b != armed_id_q);
							sum_d     = b;
							phase_d   = PH_LEN;
						end
						PH_LEN: begin
							if (b != ({4'd0, armed_len_q} + 8'd2))
								hdr_bad_d = 1'b1;
							sum_d   = sum_add;
							phase_d = PH_STATUS;
						end
						PH_STATUS: begin
							hdr_bad_d = hdr_bad_now;
							sum_d     = sum_add;
							if (hdr_bad_now) begin
								res_valid       = 1'b1;
								res.result_code = ssfr_pkg::RC_HEADER;
								phase_d         = PH_IDLE;
							end else begin
								count_d = 4'd0;
								store_d = '0;
								phase_d = (armed_len_q == 4'd0) ? PH_CHECK : PH_DATA;
							end
						end
						PH_DATA: begin
							// drop the byte into its lane
							for (int i = 0; i < MAX_PAYLOAD; i++) begin
								if (count_q == 4'(i))
									store_d[8*i +: 8] = b;
							end
							sum_d   = sum_add;
							count_d = count_inc;
							if (count_inc >= armed_len_q)
								phase_d = PH_CHECK;
						end
						PH_CHECK: begin
							res_valid = 1'b1;
							phase_d   = PH_IDLE;
							if (b == ~sum_q) begin
								res.result_code   = ssfr_pkg::RC_OK;
								res.payload_bytes = 64'(store_q);
							end else begin
								res.result_code = ssfr_pkg::RC_CHECKSUM;
							end
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end else if (item.action == ssfr_pkg::ACT_TICK) begin
					// deadline countdown
					if (ticks_q <= ssfr_pkg::TICKS_W'(1)) begin
						ticks_d         = '0;
						res_valid       = 1'b1;
						res.result_code = ssfr_pkg::RC_TIMEOUT;
						phase_d         = PH_IDLE;
					end else begin
						ticks_d = ticks_q - ssfr_pkg::TICKS_W'(1);
					end
				end
			end
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			last_ff_q   <= 1'b0;
			armed_id_q  <= 8'd0;
			armed_len_q <= 4'd0;
			hdr_bad_q   <= 1'b0;
			count_q     <= 4'd0;
			sum_q       <= 8'd0;
			store_q     <= '0;
			ticks_q     <= '0;
		end else begin
			phase_q     <= phase_d;
			last_ff_q   <= last_ff_d;
			armed_id_q  <= armed_id_d;
			armed_len_q <= armed_len_d;
			hdr_bad_q   <= hdr_bad_d;
			count_q     <= count_d;
			sum_q       <= sum_d;
			store_q     <= store_d;
			ticks_q     <= ticks_d;
		end
	end

endmodule
